// ===== rtl/core/ssg_pkg.sv =====
// shared types and constants for the speech segment grouper
// used by ssg_datapath, ssg_ctrl and speech_segment_grouper_core
`timescale 1ns / 1ps

package ssg_pkg;

  localparam int INDEX_BITS     = 24;
  localparam int ENERGY_BITS    = 32;
  localparam int SAMPLE_BITS    = 32;
  localparam int SUM_BITS       = ENERGY_BITS + INDEX_BITS;
  localparam int COUNT_BITS     = 35;
  localparam int CHAN_BITS      = 4;
  localparam int MEAN_BITS      = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;
  localparam int DIV_STEPS      = SUM_BITS;
  localparam int DIV_STEP_BITS  = $clog2(DIV_STEPS);

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_SPEECH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_SILENCE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNELS    = 2'd2;

  typedef struct packed {
    logic                   is_speech;
    logic [ENERGY_BITS-1:0] frame_energy;
    logic [SAMPLE_BITS-1:0] frame_start_sample;
    logic [SAMPLE_BITS-1:0] frame_end_sample;
    logic                   end_of_stream;
  } ssg_in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] segment_start_sample;
    logic [SAMPLE_BITS-1:0] segment_end_sample;
    logic [INDEX_BITS-1:0]  frame_span;
    logic [COUNT_BITS-1:0]  sample_count;
    logic [MEAN_BITS-1:0]   mean_energy;
  } ssg_out_t;

  typedef struct packed {
    logic take;
    logic div_step;
    logic load_out;
  } ssg_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_last;
  } ssg_status_t;

endpackage

// ===== rtl/core/ssg_datapath.sv =====
// segment state, closing snapshot, serial mean-energy divider and output register
// depends on ssg_pkg; driven by ssg_ctrl through ssg_cmd_t
`timescale 1ns / 1ps

module ssg_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [ssg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [ssg_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  ssg_pkg::ssg_in_t                     in_data,
  input  ssg_pkg::ssg_cmd_t                    cmd,
  output ssg_pkg::ssg_status_t                 status,
  output ssg_pkg::ssg_out_t                    out_data
);
  import ssg_pkg::*;

  localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};
  localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};

  // configuration
  logic [INDEX_BITS-1:0] min_speech;
  logic [INDEX_BITS-1:0] max_silence;
  logic [CHAN_BITS-1:0]  channels;

  // segment state
  logic                   segment_open;
  logic [INDEX_BITS-1:0]  frame_counter;
  logic [INDEX_BITS-1:0]  first_idx;
  logic [INDEX_BITS-1:0]  last_idx;
  logic [INDEX_BITS-1:0]  speech_count;
  logic [SUM_BITS-1:0]    energy_sum;
  logic [SAMPLE_BITS-1:0] first_start;
  logic [SAMPLE_BITS-1:0] last_end;

  // state after this frame, before any close
  logic                   upd_open;
  logic [INDEX_BITS-1:0]  upd_first_idx;
  logic [INDEX_BITS-1:0]  upd_last_idx;
  logic [INDEX_BITS-1:0]  upd_count;
  logic [SUM_BITS-1:0]    upd_sum;
  logic [SAMPLE_BITS-1:0] upd_first_start;
  logic [SAMPLE_BITS-1:0] upd_last_end;
  logic [SUM_BITS:0]      sum_wide;
  logic                   gap_close;
  logic                   closing;
  logic [INDEX_BITS-1:0]  counter_next;

  // closing snapshot
  logic [INDEX_BITS:0]       span_wide;
  logic [INDEX_BITS-1:0]     span_val;
  logic [SAMPLE_BITS-1:0]    sample_diff;
  logic [SAMPLE_BITS+CHAN_BITS-1:0] prod;
  logic [COUNT_BITS-1:0]     samples_val;
  logic [SAMPLE_BITS-1:0]    snap_start;
  logic [SAMPLE_BITS-1:0]    snap_end;
  logic [INDEX_BITS-1:0]     snap_span;
  logic [COUNT_BITS-1:0]     snap_samples;

  // divider: div_a shifts the dividend out and the quotient in
  logic [SUM_BITS-1:0]      div_a;
  logic [INDEX_BITS-1:0]    div_d;
  logic [INDEX_BITS-1:0]    div_rem;
  logic [DIV_STEP_BITS-1:0] div_cnt;
  logic [INDEX_BITS:0]      trial;
  logic [INDEX_BITS:0]      trial_diff;
  logic                     q_bit;

  always_comb begin
    upd_open        = segment_open;
    upd_first_idx   = first_idx;
    upd_last_idx    = last_idx;
    upd_count       = speech_count;
    upd_sum         = energy_sum;
    upd_first_start = first_start;
    upd_last_end    = last_end;
    sum_wide        = {1'b0, energy_sum} + {{(SUM_BITS+1-ENERGY_BITS){1'b0}}, in_data.frame_energy};
    if (in_data.is_speech) begin
      if (!segment_open) begin
        upd_open        = 1'b1;
        upd_first_idx   = frame_counter;
        upd_first_start = in_data.frame_start_sample;
      end
      upd_last_idx = frame_counter;
      upd_last_end = in_data.frame_end_sample;
      upd_count    = (speech_count == INDEX_MAX) ? INDEX_MAX : speech_count + 1'b1;
      upd_sum      = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
    end
  end

  assign gap_close = !in_data.is_speech && segment_open && (frame_counter >= last_idx) &&
                     ((frame_counter - last_idx) > max_silence);
  assign closing   = gap_close || in_data.end_of_stream;

  always_comb begin
    if (in_data.end_of_stream) begin
      counter_next = '0;
    end else if (frame_counter == INDEX_MAX) begin
      counter_next = INDEX_MAX;
    end else begin
      counter_next = frame_counter + 1'b1;
    end
  end

  assign status.emit = closing && upd_open && (upd_count != '0) && (upd_count >= min_speech);
  assign status.div_last = (div_cnt == DIV_STEP_BITS'(DIV_STEPS - 1));

  // span and sample count of the segment being closed
  always_comb begin
    span_wide = {1'b0, upd_last_idx} - {1'b0, upd_first_idx} + 1'b1;
    if (upd_last_idx < upd_first_idx) begin
      span_val = INDEX_BITS'(1);
    end else if (span_wide[INDEX_BITS]) begin
      span_val = INDEX_MAX;
    end else begin
      span_val = span_wide[INDEX_BITS-1:0];
    end
    sample_diff = (upd_last_end >= upd_first_start) ? upd_last_end - upd_first_start : '0;
    prod = {{CHAN_BITS{1'b0}}, sample_diff} * {{SAMPLE_BITS{1'b0}}, channels};
    if (|prod[SAMPLE_BITS+CHAN_BITS-1:COUNT_BITS]) begin
      samples_val = {COUNT_BITS{1'b1}};
    end else begin
      samples_val = prod[COUNT_BITS-1:0];
    end
  end

  assign trial      = {div_rem, div_a[SUM_BITS-1]};
  assign trial_diff = trial - {1'b0, div_d};
  assign q_bit      = (trial >= {1'b0, div_d});

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      min_speech    <= INDEX_BITS'(1);
      max_silence   <= '0;
      channels      <= CHAN_BITS'(1);
      segment_open  <= 1'b0;
      frame_counter <= '0;
      first_idx     <= '0;
      last_idx      <= '0;
      speech_count  <= '0;
      energy_sum    <= '0;
      first_start   <= '0;
      last_end      <= '0;
      div_cnt       <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MIN_SPEECH:  min_speech  <= cfg_data[INDEX_BITS-1:0];
          REG_MAX_SILENCE: max_silence <= cfg_data[INDEX_BITS-1:0];
          REG_CHANNELS:    channels    <= cfg_data[CHAN_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.take) begin
        frame_counter <= counter_next;
        div_cnt       <= '0;
        if (closing) begin
          segment_open <= 1'b0;
          first_idx    <= '0;
          last_idx     <= '0;
          speech_count <= '0;
          energy_sum   <= '0;
          first_start  <= '0;
          last_end     <= '0;
        end else begin
          segment_open <= upd_open;
          first_idx    <= upd_first_idx;
          last_idx     <= upd_last_idx;
          speech_count <= upd_count;
          energy_sum   <= upd_sum;
          first_start  <= upd_first_start;
          last_end     <= upd_last_end;
        end
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + 1'b1;
      end
    end
  end

  // snapshot, divider and output payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      snap_start   <= upd_first_start;
      snap_end     <= upd_last_end;
      snap_span    <= span_val;
      snap_samples <= samples_val;
      div_a        <= upd_sum;
      div_d        <= upd_count;
      div_rem      <= '0;
    end else if (cmd.div_step) begin
      div_rem <= q_bit ? trial_diff[INDEX_BITS-1:0] : trial[INDEX_BITS-1:0];
      div_a   <= {div_a[SUM_BITS-2:0], q_bit};
    end
    if (cmd.load_out) begin
      out_data.segment_start_sample <= snap_start;
      out_data.segment_end_sample   <= snap_end;
      out_data.frame_span           <= snap_span;
      out_data.sample_count         <= snap_samples;
      out_data.mean_energy          <= (|div_a[SUM_BITS-1:MEAN_BITS]) ? {MEAN_BITS{1'b1}}
                                                                       : div_a[MEAN_BITS-1:0];
    end
  end

endmodule

// ===== rtl/core/ssg_ctrl.sv =====
// control state machine: input transfer, divider sequencing, output handshake
// depends on ssg_pkg; commands ssg_datapath
`timescale 1ns / 1ps

module ssg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ssg_pkg::ssg_status_t status,
  output ssg_pkg::ssg_cmd_t    cmd
);
  import ssg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // no transfer is taken while reset is held
  assign in_ready = (state == S_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.take     = in_valid && in_ready;
    cmd.div_step = (state == S_DIV);
    cmd.load_out = (state == S_HOLD) && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.take && status.emit) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (status.div_last) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_emit_starts_div: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && status.emit) |=> (state == S_DIV))
    else $error("closing transfer did not start the divider");

  a_div_to_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && status.div_last) |=> (state == S_HOLD))
    else $error("divider did not hand over to output hold");

  a_load_only_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten before transfer");

  a_result_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_HOLD))
    else $error("result shown without finished divide");

endmodule

// ===== rtl/core/speech_segment_grouper_core.sv =====
// top level of the speech segment grouper: controller plus datapath
// depends on ssg_pkg, ssg_ctrl, ssg_datapath
//
// channel   signals                         payload
// input     in_valid / in_ready             in_data  (ssg_in_t)
// output    out_valid / out_ready           out_data (ssg_out_t)
// config    cfg_wr_en, cfg_index            cfg_data (24 bit, write only)
//
// a frame that closes no emitted segment leaves the controller idle; frames can follow back to back
// a frame that emits a segment holds the input, plus any output stall, through these steps:
//   the transfer, the one-bit-per-cycle restoring divider for
//   mean energy, and the load of the output register
// the output register lets a finished result wait while further frames are taken
// reset (rst, synchronous) clears segment state, frame counter and config to defaults
`timescale 1ns / 1ps

module speech_segment_grouper_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ssg_pkg::ssg_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ssg_pkg::ssg_out_t                  out_data,
  input  logic                               cfg_wr_en,
  input  logic [ssg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ssg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import ssg_pkg::*;

  ssg_cmd_t    cmd;
  ssg_status_t status;

  ssg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ssg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ===== sim/speech_segment_grouper_core_test.sv =====
// self-checking testbench for speech_segment_grouper_core: directed and random frames,
// a behavioral predictor of segment grouping, and random sender gaps and receiver stalls
// depends on ssg_pkg and speech_segment_grouper_core
`timescale 1ns / 1ps

module speech_segment_grouper_core_test;
  import ssg_pkg::*;

  localparam int SETTLE_CYCLES = 80;
  localparam int TIMEOUT_NS    = 5_000_000;
  localparam int RANDOM_FRAMES = 140;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  ssg_in_t                   in_data;
  logic                      out_valid;
  logic                      out_ready;
  ssg_out_t                  out_data;
  logic                      cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  speech_segment_grouper_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of configuration and segment state
  logic [INDEX_BITS-1:0]  min_frames_cfg;
  logic [INDEX_BITS-1:0]  max_gap_cfg;
  logic [CHAN_BITS-1:0]   channels_cfg;
  logic                   seg_open;
  logic [INDEX_BITS-1:0]  frame_idx;
  logic [INDEX_BITS-1:0]  seg_first_idx;
  logic [INDEX_BITS-1:0]  seg_last_idx;
  logic [INDEX_BITS-1:0]  seg_speech_frames;
  logic [SUM_BITS-1:0]    seg_energy_sum;
  logic [SAMPLE_BITS-1:0] seg_start;
  logic [SAMPLE_BITS-1:0] seg_end;

  ssg_out_t expected_segments[$];
  int       mismatch_count;
  int       frames_sent;
  int       segments_checked;
  int       send_gap_pct;
  int       recv_stall_pct;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void drop_segment();
    seg_open          = 1'b0;
    seg_first_idx     = '0;
    seg_last_idx      = '0;
    seg_speech_frames = '0;
    seg_energy_sum    = '0;
    seg_start         = '0;
    seg_end           = '0;
  endfunction

  // summary of the open segment, if it holds enough speech frames
  function automatic logic summarize_segment(output ssg_out_t seg);
    logic [INDEX_BITS:0]    span_wide;
    logic [SAMPLE_BITS-1:0] diff;
    logic [39:0]            product;
    logic [SUM_BITS-1:0]    quotient;
    seg = '0;
    if (!seg_open || seg_speech_frames < min_frames_cfg || seg_speech_frames == 0)
      return 1'b0;
    span_wide = (INDEX_BITS+1)'(seg_last_idx) - (INDEX_BITS+1)'(seg_first_idx) + 1'b1;
    if (seg_last_idx < seg_first_idx)
      seg.frame_span = INDEX_BITS'(1);
    else if (span_wide[INDEX_BITS])
      seg.frame_span = '1;
    else
      seg.frame_span = span_wide[INDEX_BITS-1:0];
    diff = (seg_end >= seg_start) ? seg_end - seg_start : '0;
    product = 40'(diff) * 40'(channels_cfg);
    seg.sample_count = (product > 40'h7_FFFF_FFFF) ? '1 : product[COUNT_BITS-1:0];
    quotient = seg_energy_sum / SUM_BITS'(seg_speech_frames);
    seg.mean_energy = (quotient > SUM_BITS'(32'hFFFF_FFFF)) ? '1 : quotient[MEAN_BITS-1:0];
    seg.segment_start_sample = seg_start;
    seg.segment_end_sample   = seg_end;
    return 1'b1;
  endfunction

  function automatic logic predict_frame(input ssg_in_t f, output ssg_out_t seg);
    logic                  closed;
    logic [INDEX_BITS-1:0] idx;
    logic [SUM_BITS:0]     sum;
    closed = 1'b0;
    idx    = frame_idx;
    seg    = '0;
    if (f.is_speech) begin
      if (!seg_open) begin
        seg_open      = 1'b1;
        seg_first_idx = idx;
        seg_start     = f.frame_start_sample;
      end
      seg_last_idx = idx;
      seg_end      = f.frame_end_sample;
      if (seg_speech_frames != '1)
        seg_speech_frames = seg_speech_frames + 1'b1;
      sum = {1'b0, seg_energy_sum} + (SUM_BITS+1)'(f.frame_energy);
      seg_energy_sum = sum[SUM_BITS] ? '1 : sum[SUM_BITS-1:0];
    end else if (seg_open && idx >= seg_last_idx && idx - seg_last_idx > max_gap_cfg) begin
      closed = summarize_segment(seg);
      drop_segment();
    end
    if (frame_idx != '1)
      frame_idx = frame_idx + 1'b1;
    if (f.end_of_stream) begin
      if (!closed)
        closed = summarize_segment(seg);
      drop_segment();
      frame_idx = '0;
    end
    return closed;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // prediction on each input transfer, comparison on each output transfer
  always @(posedge clk) begin
    ssg_out_t seg;
    ssg_out_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (predict_frame(in_data, seg))
          expected_segments.insert(expected_segments.size(), seg);
        frames_sent++;
      end
      if (out_valid && out_ready) begin
        segments_checked++;
        if (expected_segments.size() == 0) begin
          $display("%0t: segment expected none, got start %0h end %0h span %0h",
                   $time, out_data.segment_start_sample, out_data.segment_end_sample,
                   out_data.frame_span);
          mismatch_count++;
        end else begin
          want = expected_segments.pop_front();
          check_field("segment_start_sample", want.segment_start_sample,
                      out_data.segment_start_sample);
          check_field("segment_end_sample", want.segment_end_sample,
                      out_data.segment_end_sample);
          check_field("frame_span", want.frame_span, out_data.frame_span);
          check_field("sample_count", want.sample_count, out_data.sample_count);
          check_field("mean_energy", want.mean_energy, out_data.mean_energy);
        end
      end
    end
  end

  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  function automatic ssg_in_t make_frame(input logic speech, input logic [31:0] energy,
                                         input logic [31:0] from_sample,
                                         input logic [31:0] to_sample, input logic eos);
    ssg_in_t f;
    f.is_speech          = speech;
    f.frame_energy       = energy;
    f.frame_start_sample = from_sample;
    f.frame_end_sample   = to_sample;
    f.end_of_stream      = eos;
    return f;
  endfunction

  task automatic send_frame(input ssg_in_t f);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // called in the step of the last transfer so the item is not offered twice
  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  // all segments delivered, then room for a divide still in flight
  task automatic settle();
    // wait for an edge first so the prediction of the last transfer is queued
    @(posedge clk);
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [INDEX_BITS-1:0] min_frames,
                              input logic [INDEX_BITS-1:0] max_gap,
                              input logic [CHAN_BITS-1:0] chans);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_MIN_SPEECH;
    cfg_data  <= min_frames;
    @(posedge clk);
    cfg_index <= REG_MAX_SILENCE;
    cfg_data  <= max_gap;
    @(posedge clk);
    cfg_index <= REG_CHANNELS;
    cfg_data  <= CFG_DATA_BITS'(chans);
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    min_frames_cfg = min_frames;
    max_gap_cfg    = max_gap;
    channels_cfg   = chans;
  endtask

  // default registers: widest energy and samples, reversed sample range, silence alone
  task automatic test_field_extremes();
    settle();
    send_frame(make_frame(1'b1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1));
    send_frame(make_frame(1'b1, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1));
    send_frame(make_frame(1'b0, 32'h1234_5678, 32'h100, 32'h200, 1'b1));
    release_input();
  endtask

  // gap of two bridged, gap of three closes on its third silence frame
  task automatic test_gap_bridging();
    settle();
    write_config(24'd1, 24'd2, 4'd2);
    send_frame(make_frame(1'b1, 32'h0001_0000, 32'd0, 32'd160, 1'b0));
    send_frame(make_frame(1'b0, 32'h0000_0100, 32'd160, 32'd320, 1'b0));
    send_frame(make_frame(1'b0, 32'h0000_0100, 32'd320, 32'd480, 1'b0));
    send_frame(make_frame(1'b1, 32'h0003_0000, 32'd480, 32'd640, 1'b0));
    send_frame(make_frame(1'b0, 32'h0, 32'd640, 32'd800, 1'b0));
    send_frame(make_frame(1'b0, 32'h0, 32'd800, 32'd960, 1'b0));
    send_frame(make_frame(1'b0, 32'h0, 32'd960, 32'd1120, 1'b0));
    send_frame(make_frame(1'b0, 32'h0, 32'd1120, 32'd1280, 1'b1));
    release_input();
  endtask

  // end of stream on the frame whose silence already closed the segment gives one result
  task automatic test_close_on_end();
    settle();
    write_config(24'd1, 24'd0, 4'd1);
    send_frame(make_frame(1'b1, 32'h0002_8000, 32'd5000, 32'd5400, 1'b0));
    send_frame(make_frame(1'b0, 32'h0, 32'd5400, 32'd5800, 1'b1));
    send_frame(make_frame(1'b1, 32'h0000_0003, 32'd6000, 32'd6100, 1'b0));
    send_frame(make_frame(1'b1, 32'h0000_0004, 32'd6100, 32'd6200, 1'b1));
    release_input();
  endtask

  // too few speech frames, minimum of zero, largest minimum
  task automatic test_min_speech();
    settle();
    write_config(24'd3, 24'd1, 4'd1);
    send_frame(make_frame(1'b1, 32'h10, 32'd0, 32'd10, 1'b0));
    send_frame(make_frame(1'b1, 32'h20, 32'd10, 32'd20, 1'b0));
    send_frame(make_frame(1'b0, 32'h0, 32'd20, 32'd30, 1'b1));
    release_input();
    settle();
    write_config(24'd0, 24'd1, 4'd1);
    send_frame(make_frame(1'b1, 32'h7, 32'd40, 32'd50, 1'b1));
    release_input();
    settle();
    write_config(24'hFF_FFFF, 24'd1, 4'd1);
    send_frame(make_frame(1'b1, 32'h7, 32'd60, 32'd70, 1'b1));
    release_input();
  endtask

  // zero channels, largest hangover, and a product past 35 bits
  task automatic test_channel_extremes();
    settle();
    write_config(24'd1, 24'hFF_FFFF, 4'd0);
    send_frame(make_frame(1'b1, 32'h0000_8000, 32'd0, 32'd1000, 1'b0));
    send_frame(make_frame(1'b0, 32'h0, 32'd1000, 32'd2000, 1'b0));
    send_frame(make_frame(1'b1, 32'h0001_8000, 32'd2000, 32'd3000, 1'b1));
    release_input();
    settle();
    write_config(24'd1, 24'd0, 4'd15);
    send_frame(make_frame(1'b1, 32'hDEAD_BEEF, 32'd0, 32'hFFFF_FFFF, 1'b1));
    release_input();
  endtask

  // speech bursts and silence runs around the hangover limit, with some noise frames
  task automatic run_random_frames(input int count);
    int          sent;
    int          speech_left;
    int          quiet_left;
    logic [31:0] cursor;
    logic [31:0] len;
    ssg_in_t     f;
    sent        = 0;
    speech_left = 0;
    quiet_left  = 0;
    cursor      = $urandom;
    while (sent < count) begin
      if (speech_left == 0 && quiet_left == 0) begin
        speech_left = $urandom_range(1, 5);
        quiet_left  = $urandom_range(0, (max_gap_cfg > 4) ? 6 : int'(max_gap_cfg) + 2);
      end
      f.is_speech = (speech_left != 0);
      if (speech_left != 0)
        speech_left--;
      else
        quiet_left--;
      len = ($urandom_range(15) == 0) ? $urandom : $urandom_range(1, 4096);
      f.frame_start_sample = cursor;
      f.frame_end_sample   = cursor + len;
      cursor               = cursor + len;
      case ($urandom_range(7))
        0:       f.frame_energy = '0;
        1:       f.frame_energy = '1;
        default: f.frame_energy = $urandom;
      endcase
      f.end_of_stream = ($urandom_range(24) == 0);
      if ($urandom_range(9) == 0) begin
        f.is_speech          = 1'($urandom_range(1));
        f.frame_start_sample = $urandom;
        f.frame_end_sample   = $urandom;
        f.end_of_stream      = ($urandom_range(7) == 0);
      end
      send_frame(f);
      sent++;
    end
    release_input();
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct);
    settle();
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    repeat (2) begin
      settle();
      write_config(24'($urandom_range(0, 4)),
                   ($urandom_range(5) == 0) ? 24'hFF_FFFF : 24'($urandom_range(0, 5)),
                   ($urandom_range(3) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 8)));
      run_random_frames(RANDOM_FRAMES);
    end
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    in_data        <= '0;
    out_ready      <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= REG_MIN_SPEECH;
    cfg_data       <= '0;
    mismatch_count = 0;
    frames_sent    = 0;
    segments_checked = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    min_frames_cfg = 24'd1;
    max_gap_cfg    = '0;
    channels_cfg   = 4'd1;
    frame_idx      = '0;
    drop_segment();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_gap_bridging();
    test_close_on_end();
    test_min_speech();
    test_channel_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(66, 0);
    test_random_traffic(0, 66);
    test_random_traffic(10, 10);
    settle();

    $display("%0d frames sent and %0d segments checked across directed cases",
             frames_sent, segments_checked);
    $display("and random bursts under four sender/receiver idling mixes");
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ssg_pkg.sv
rtl/core/ssg_datapath.sv
rtl/core/ssg_ctrl.sv
rtl/core/speech_segment_grouper_core.sv
sim/speech_segment_grouper_core_test.sv
